// ===== src/sis_pkg.sv =====
// Shared types and constants of the sorted index set block.
// No dependencies; imported by sorted_index_set_core, sis_checker and tb_sorted_index_set_core.
package sis_pkg;

   // Request command codes.
   localparam logic [3:0] CMD_CONTAINS    = 4'd0;
   localparam logic [3:0] CMD_ADD         = 4'd1;
   localparam logic [3:0] CMD_REMOVE      = 4'd2;
   localparam logic [3:0] CMD_TOGGLE      = 4'd3;
   localparam logic [3:0] CMD_SELECT_ONLY = 4'd4;
   localparam logic [3:0] CMD_CLEAR       = 4'd5;
   localparam logic [3:0] CMD_FILL        = 4'd6;
   localparam logic [3:0] CMD_SHIFT_UP    = 4'd7;
   localparam logic [3:0] CMD_SHIFT_DOWN  = 4'd8;
   localparam logic [3:0] CMD_SWAP        = 4'd9;
   localparam logic [3:0] CMD_GET         = 4'd10;

   // Width of the signed search keys and of the wide unsigned range values.
   localparam int KEY_W  = 34;
   localparam int WIDE_W = 33;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_REMOVE,
      S_INSERT,
      S_ADJUST,
      S_FILL,
      S_READ,
      S_SELECT,
      S_RESP
   } state_type;

endpackage

// ===== src/sis_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the entry store of sorted_index_set_core.
module sis_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/sorted_index_set_core.sv =====
// Sorted index set: keeps an ascending set of distinct indexes in one RAM.
// Depends on sis_pkg and sis_ram.
//
// Usage: a request (command, value, second_value) is taken on req_valid with
// req_stall low; exactly one response (status, found, read_value, count)
// follows on the rsp_ channel. One request is worked on at a time; req_stall
// is high from acceptance until the response is loaded into the output
// register, so the next request can be taken while a response waits.
// The mode register is written through csr_wr_en / csr_wr_data; the user must
// do so only while idle, which the block itself does not enforce.
//
// All walks move one entry per cycle through the single read and single write
// port of the entry RAM.
// Reset empties the set and selects single mode; entry RAM is not cleared.
// When the receiver stalls, the response is held and the block keeps the
// finished result of the next request until the output register frees.
module sorted_index_set_core #(
   parameter int CAPACITY   = 64,
   parameter int INDEX_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_command,
   input  logic signed [16:0] req_value,
   input  logic [15:0]        req_second_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_status,
   output logic               rsp_found,
   output logic signed [16:0] rsp_read_value,
   output logic [6:0]         rsp_count,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);
   import sis_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [WIDE_W-1:0] IDX_MAX_W = (WIDE_W'(1) << INDEX_BITS) - WIDE_W'(1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   state_type state_ff, state_in;
   logic [3:0] cmd_ff, cmd_in;
   logic mode_ff;
   logic signed [KEY_W-1:0] key_a_ff, key_a_in, key_b_ff, key_b_in, fkey_ff, fkey_in;
   logic [INDEX_BITS-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in, ins_ff, ins_in;
   logic va_ok_ff, va_ok_in, vb_ok_ff, vb_ok_in, neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in, ptr_ff, ptr_in, pos_ff, pos_in, pa_ff, pa_in;
   logic [AW-1:0] chk_ff, chk_in;
   logic pend_ff, pend_in, hit_ff, hit_in, ha_ff, ha_in;
   logic ovf_ff, ovf_in, up_ff, up_in;
   logic [1:0] phase_ff, phase_in;
   logic [WIDE_W-1:0] fx_ff, fx_in, fe_ff, fe_in;
   logic status_ff, status_in, found_ff, found_in;
   logic signed [16:0] rv_ff, rv_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_status_ff, out_status_in, out_found_ff, out_found_in;
   logic signed [16:0] out_rv_ff, out_rv_in;
   logic [6:0] out_cnt_ff, out_cnt_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [INDEX_BITS-1:0] wr_data, rd_data;
   logic signed [KEY_W-1:0] rd_key, key_a_w, key_b_w;
   logic [WIDE_W-1:0] v_wide, v2_wide, rd_wide, cnt_wide;
   logic va_ok_w, vb_ok_w;

   sis_ram #(.WIDTH(INDEX_BITS), .DEPTH(CAPACITY)) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (1'b1),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign v_wide   = WIDE_W'(req_value[15:0]);
   assign v2_wide  = WIDE_W'(req_second_value);
   assign rd_wide  = WIDE_W'(rd_data);
   assign cnt_wide = WIDE_W'(cnt_ff);
   assign key_a_w  = KEY_W'(req_value);
   assign key_b_w  = {(KEY_W - 16)'(0), req_second_value};
   assign rd_key   = {(KEY_W - INDEX_BITS)'(0), rd_data};
   assign va_ok_w  = !req_value[16] && (v_wide <= IDX_MAX_W);
   assign vb_ok_w  = v2_wide <= IDX_MAX_W;

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_found      = out_found_ff;
   assign rsp_read_value = out_rv_ff;
   assign rsp_count      = out_cnt_ff;

   always_comb begin
      logic [CW-1:0] p_new;
      logic          add_go;
      p_new         = pos_ff;
      add_go        = 1'b0;
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_a_in      = key_a_ff;
      key_b_in      = key_b_ff;
      fkey_in       = fkey_ff;
      idx_a_in      = idx_a_ff;
      idx_b_in      = idx_b_ff;
      ins_in        = ins_ff;
      va_ok_in      = va_ok_ff;
      vb_ok_in      = vb_ok_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      pa_in         = pa_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      hit_in        = hit_ff;
      ha_in         = ha_ff;
      ovf_in        = ovf_ff;
      up_in         = up_ff;
      phase_in      = phase_ff;
      fx_in         = fx_ff;
      fe_in         = fe_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rv_in         = rv_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_found_in  = out_found_ff;
      out_rv_in     = out_rv_ff;
      out_cnt_in    = out_cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_ff;
      wr_data       = rd_data;
      rd_addr       = ptr_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               key_a_in  = key_a_w;
               key_b_in  = key_b_w;
               fkey_in   = key_a_w;
               idx_a_in  = v_wide[INDEX_BITS-1:0];
               idx_b_in  = v2_wide[INDEX_BITS-1:0];
               va_ok_in  = va_ok_w;
               vb_ok_in  = vb_ok_w;
               neg_in    = req_value[16];
               status_in = 1'b0;
               found_in  = 1'b0;
               rv_in     = '1;
               phase_in  = 2'd0;
               pend_in   = 1'b0;
               ptr_in    = '0;
               fx_in     = req_value[16] ? '0 : v_wide;
               fe_in     = (v2_wide > IDX_MAX_W) ? IDX_MAX_W : v2_wide;
               unique case (req_command)
                  CMD_CONTAINS: state_in = S_FIND;
                  CMD_ADD, CMD_REMOVE: begin
                     if (!mode_ff && req_command == CMD_ADD) begin
                        state_in = S_SELECT;
                     end else begin
                        state_in = va_ok_w ? S_FIND : S_RESP;
                     end
                  end
                  CMD_TOGGLE: begin
                     if (mode_ff) begin
                        state_in = va_ok_w ? S_FIND : S_RESP;
                     end else begin
                        state_in = (cnt_ff != '0) ? S_READ : S_SELECT;
                     end
                  end
                  CMD_SELECT_ONLY: state_in = S_SELECT;
                  CMD_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_RESP;
                  end
                  CMD_FILL: begin
                     cnt_in   = '0;
                     state_in = S_FILL;
                  end
                  CMD_SHIFT_UP: begin
                     up_in    = 1'b1;
                     state_in = S_FIND;
                  end
                  CMD_SHIFT_DOWN: begin
                     up_in    = 1'b0;
                     state_in = va_ok_w ? S_FIND : S_RESP;
                  end
                  CMD_SWAP: state_in = (va_ok_w && vb_ok_w) ? S_FIND : S_RESP;
                  CMD_GET: begin
                     if (!req_value[16] && v_wide < cnt_wide) begin
                        ptr_in   = v_wide[CW-1:0];
                        state_in = S_READ;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_FIND: begin
            if ((pend_ff && rd_key >= fkey_ff) || (!(pend_ff && rd_key >= fkey_ff)
                  && ptr_ff >= cnt_ff)) begin
               // Lower bound found: first entry not below the key, or the end.
               if (pend_ff && rd_key >= fkey_ff) begin
                  p_new  = CW'(chk_ff);
                  hit_in = (rd_key == fkey_ff);
               end else begin
                  p_new  = cnt_ff;
                  hit_in = 1'b0;
               end
               pos_in  = p_new;
               pend_in = 1'b0;
               state_in = S_RESP;
               priority case (cmd_ff)
                  CMD_CONTAINS: found_in = hit_in;
                  CMD_ADD: add_go = !hit_in;
                  CMD_REMOVE, CMD_TOGGLE, CMD_SHIFT_DOWN: begin
                     if (hit_in) begin
                        ptr_in   = p_new + CW'(1);
                        state_in = S_REMOVE;
                     end else if (cmd_ff == CMD_TOGGLE) begin
                        add_go = 1'b1;
                     end else if (cmd_ff == CMD_SHIFT_DOWN) begin
                        ptr_in   = p_new;
                        ovf_in   = 1'b0;
                        state_in = S_ADJUST;
                     end
                  end
                  CMD_SHIFT_UP: begin
                     ptr_in   = p_new;
                     ovf_in   = 1'b0;
                     state_in = S_ADJUST;
                  end
                  CMD_SWAP: begin
                     if (phase_ff == 2'd0) begin
                        pa_in    = p_new;
                        ha_in    = hit_in;
                        fkey_in  = key_b_ff;
                        ptr_in   = '0;
                        phase_in = 2'd1;
                        state_in = S_FIND;
                     end else if (phase_ff == 2'd1) begin
                        if (ha_ff && !hit_in) begin
                           pos_in   = pa_ff;
                           ptr_in   = pa_ff + CW'(1);
                           ins_in   = idx_b_ff;
                           fkey_in  = key_b_ff;
                           phase_in = 2'd2;
                           state_in = S_REMOVE;
                        end else if (hit_in && !ha_ff) begin
                           ptr_in   = p_new + CW'(1);
                           ins_in   = idx_a_ff;
                           fkey_in  = key_a_ff;
                           phase_in = 2'd2;
                           state_in = S_REMOVE;
                        end
                     end else begin
                        ptr_in   = cnt_ff;
                        state_in = S_INSERT;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
               if (add_go) begin
                  if (cnt_ff == CAP_C) begin
                     status_in = 1'b1;
                  end else begin
                     ins_in   = idx_a_ff;
                     ptr_in   = cnt_ff;
                     state_in = S_INSERT;
                  end
               end
            end else begin
               rd_addr = ptr_ff[AW-1:0];
               chk_in  = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               ptr_in  = ptr_ff + CW'(1);
            end
         end

         S_REMOVE: begin
            // Close the gap: entry i+1 moves down to i.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff;
               wr_data = rd_data;
            end
            if (ptr_ff < cnt_ff) begin
               rd_addr = ptr_ff[AW-1:0];
               chk_in  = AW'(ptr_ff - CW'(1));
               pend_in = 1'b1;
               ptr_in  = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               cnt_in = cnt_ff - CW'(1);
               if (cmd_ff == CMD_SHIFT_DOWN) begin
                  ptr_in   = pos_ff;
                  ovf_in   = 1'b0;
                  state_in = S_ADJUST;
               end else if (cmd_ff == CMD_SWAP) begin
                  ptr_in   = '0;
                  state_in = S_FIND;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               pend_in = 1'b0;
            end
         end

         S_INSERT: begin
            // Walk down from the top, moving entry i up to i+1.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff;
               wr_data = rd_data;
            end
            if (ptr_ff > pos_ff) begin
               rd_addr = AW'(ptr_ff - CW'(1));
               chk_in  = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               ptr_in  = ptr_ff - CW'(1);
            end else if (!pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = ins_ff;
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               pend_in = 1'b0;
            end
         end

         S_ADJUST: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff;
               wr_data = up_ff ? rd_data + INDEX_BITS'(1) : rd_data - INDEX_BITS'(1);
               if (up_ff && rd_wide == IDX_MAX_W) begin
                  ovf_in = 1'b1;
               end
            end
            if (ptr_ff < cnt_ff) begin
               rd_addr = ptr_ff[AW-1:0];
               chk_in  = ptr_ff[AW-1:0];
               pend_in = 1'b1;
               ptr_in  = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               // The top entry wrapped past the index range and is dropped.
               if (ovf_ff) begin
                  cnt_in = cnt_ff - CW'(1);
               end
               state_in = S_RESP;
            end else begin
               pend_in = 1'b0;
            end
         end

         S_FILL: begin
            wr_addr = cnt_ff[AW-1:0];
            wr_data = fx_ff[INDEX_BITS-1:0];
            if (fx_ff > fe_ff) begin
               state_in = S_RESP;
            end else if (!mode_ff) begin
               wr_en    = 1'b1;
               cnt_in   = CW'(1);
               state_in = S_RESP;
            end else if (cnt_ff == CAP_C) begin
               status_in = 1'b1;
               state_in  = S_RESP;
            end else begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               fx_in  = fx_ff + WIDE_W'(1);
            end
         end

         S_READ: begin
            rd_addr = ptr_ff[AW-1:0];
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (cmd_ff == CMD_GET) begin
                  rv_in    = rd_wide[16:0];
                  state_in = S_RESP;
               end else if (rd_key == key_a_ff) begin
                  cnt_in   = '0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SELECT;
               end
            end
         end

         S_SELECT: begin
            wr_addr = '0;
            wr_data = idx_a_ff;
            if (neg_ff) begin
               cnt_in = '0;
            end else if (va_ok_ff) begin
               wr_en  = 1'b1;
               cnt_in = CW'(1);
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_found_in  = found_ff;
               out_rv_in     = rv_ff;
               out_cnt_in    = cnt_wide[6:0];
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_a_ff      <= key_a_in;
      key_b_ff      <= key_b_in;
      fkey_ff       <= fkey_in;
      idx_a_ff      <= idx_a_in;
      idx_b_ff      <= idx_b_in;
      ins_ff        <= ins_in;
      va_ok_ff      <= va_ok_in;
      vb_ok_ff      <= vb_ok_in;
      neg_ff        <= neg_in;
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      pa_ff         <= pa_in;
      chk_ff        <= chk_in;
      hit_ff        <= hit_in;
      ha_ff         <= ha_in;
      ovf_ff        <= ovf_in;
      up_ff         <= up_in;
      phase_ff      <= phase_in;
      fx_ff         <= fx_in;
      fe_ff         <= fe_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rv_ff         <= rv_in;
      out_status_ff <= out_status_in;
      out_found_ff  <= out_found_in;
      out_rv_ff     <= out_rv_in;
      out_cnt_ff    <= out_cnt_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_C)
      else $error("entry count above capacity");

   a_wr_addr: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < CAP_C))
      else $error("entry write outside the store");

   a_find_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND && pend_ff) |-> (CW'(chk_ff) < cnt_ff))
      else $error("search read beyond the held entries");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("request accepted but block stayed idle");
`endif

endmodule

// ===== verif/sis_checker.sv =====
// Checker for the sorted index set: watches both channels, predicts each response.
// Depends on sis_pkg; instantiated by tb_sorted_index_set_core.
module sis_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [3:0]         req_command,
   input  logic signed [16:0] req_value,
   input  logic [15:0]        req_second_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_status,
   input  logic               rsp_found,
   input  logic signed [16:0] rsp_read_value,
   input  logic [6:0]         rsp_count,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output int                 error_count,
   output int                 pending_count,
   output int                 response_total
);
   import sis_pkg::*;

   localparam int SET_CAP = 64;
   localparam int IDX_MAX = 65535;

   typedef struct packed {
      logic               status;
      logic               found;
      logic signed [16:0] read_value;
      logic [6:0]         count;
   } sis_rsp_type;

   int          set_idx[SET_CAP];
   int          set_size;
   logic        multi_mode;
   sis_rsp_type rsp_queue[$];

   assign pending_count = rsp_queue.size();

   function automatic int lower_pos(int v);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = set_size;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (set_idx[mid] < v) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic bit in_range(int v);
      return v >= 0 && v <= IDX_MAX;
   endfunction

   function automatic bit holds(int v);
      int p;
      p = lower_pos(v);
      return in_range(v) && p < set_size && set_idx[p] == v;
   endfunction

   task automatic drop_at(int p);
      if (p < set_size) begin
         for (int i = p; i < set_size - 1; i++) set_idx[i] = set_idx[i + 1];
         set_size--;
      end
   endtask

   task automatic insert_idx(int v, output logic full);
      int p;
      full = 0;
      p = lower_pos(v);
      if (!in_range(v) || holds(v)) return;
      if (set_size >= SET_CAP) begin
         full = 1;
         return;
      end
      for (int i = set_size; i > p; i--) set_idx[i] = set_idx[i - 1];
      set_idx[p] = v;
      set_size++;
   endtask

   task automatic pick_only(int v);
      if (v < 0) set_size = 0;
      else if (v <= IDX_MAX) begin
         set_idx[0] = v;
         set_size = 1;
      end
   endtask

   task automatic apply_request(logic [3:0] cmd, int v, int v2, output sis_rsp_type r);
      int   p;
      int   s;
      bit   ha;
      bit   hb;
      logic full;
      r = '{status: 0, found: 0, read_value: -17'sd1, count: 0};
      full = 0;
      case (cmd)
         CMD_CONTAINS: r.found = holds(v);
         CMD_ADD: begin
            if (multi_mode) insert_idx(v, full);
            else pick_only(v);
         end
         CMD_REMOVE: if (holds(v)) drop_at(lower_pos(v));
         CMD_TOGGLE: begin
            if (multi_mode) begin
               if (holds(v)) drop_at(lower_pos(v));
               else insert_idx(v, full);
            end else if (set_size > 0 && set_idx[0] == v) set_size = 0;
            else pick_only(v);
         end
         CMD_SELECT_ONLY: pick_only(v);
         CMD_CLEAR: set_size = 0;
         CMD_FILL: begin
            s = v < 0 ? 0 : v;
            set_size = 0;
            if (s <= v2) begin
               if (!multi_mode) pick_only(s);
               else begin
                  for (int x = s; x <= v2; x++) begin
                     if (set_size >= SET_CAP) begin
                        full = 1;
                        break;
                     end
                     set_idx[set_size++] = x;
                  end
               end
            end
         end
         CMD_SHIFT_UP: begin
            p = lower_pos(v);
            for (int i = p; i < set_size; i++) set_idx[i]++;
            if (set_size > p && set_idx[set_size - 1] > IDX_MAX) set_size--;
         end
         CMD_SHIFT_DOWN: begin
            if (in_range(v)) begin
               p = lower_pos(v);
               if (holds(v)) drop_at(p);
               for (int i = p; i < set_size; i++) set_idx[i]--;
            end
         end
         CMD_SWAP: begin
            if (in_range(v)) begin
               ha = holds(v);
               hb = holds(v2);
               if (ha && !hb) begin
                  drop_at(lower_pos(v));
                  insert_idx(v2, full);
               end else if (hb && !ha) begin
                  drop_at(lower_pos(v2));
                  insert_idx(v, full);
               end
               full = 0;
            end
         end
         CMD_GET: if (v >= 0 && v < set_size) r.read_value = 17'(set_idx[v]);
         default: ;
      endcase
      r.status = full;
      r.count = 7'(set_size);
   endtask

   always @(posedge clock) begin
      sis_rsp_type r;
      sis_rsp_type want;
      if (reset) begin
         set_size = 0;
         multi_mode = 0;
         error_count <= 0;
         response_total <= 0;
         rsp_queue.delete();
      end else begin
         if (csr_wr_en) multi_mode = csr_wr_data;
         if (req_valid && !req_stall) begin
            apply_request(req_command, int'(req_value), int'(req_second_value), r);
            rsp_queue.push_back(r);
         end
         if (rsp_valid && !rsp_stall) begin
            response_total <= response_total + 1;
            if (rsp_queue.size() == 0) begin
               $display("%0t: response with no request pending: %0d %0d %0d %0d", $time,
                  rsp_status, rsp_found, rsp_read_value, rsp_count);
               error_count <= error_count + 1;
            end else begin
               want = rsp_queue.pop_front();
               if (want.status !== rsp_status || want.found !== rsp_found ||
                   want.read_value !== rsp_read_value || want.count !== rsp_count) begin
                  $display({"%0t: mismatch expected st=%0d fd=%0d rv=%0d cnt=%0d,",
                            " got st=%0d fd=%0d rv=%0d cnt=%0d"},
                     $time, want.status, want.found, want.read_value, want.count,
                     rsp_status, rsp_found, rsp_read_value, rsp_count);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb_sorted_index_set_core.sv =====
// Testbench top for sorted_index_set_core: drives requests and mode writes.
// Depends on sis_pkg, sorted_index_set_core and sis_checker.
module tb_sorted_index_set_core;
   import sis_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_command;
   logic signed [16:0] req_value;
   logic [15:0]        req_second_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_status;
   logic               rsp_found;
   logic signed [16:0] rsp_read_value;
   logic [6:0]         rsp_count;
   logic               csr_wr_en;
   logic               csr_wr_data;
   int                 error_count;
   int                 pending_count;
   int                 response_total;
   int                 burst_left;
   int                 stall_mode;

   sorted_index_set_core i_dut (.*);

   sis_checker i_checker (.*);

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Receiver stall pattern: switches at random among four styles, from never stalling to mostly stalling.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= $urandom_range(0, 3) == 0;
            2: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= $urandom_range(0, 9) != 0;
         endcase
      end
   end

   task automatic write_mode(logic m);
      csr_wr_en <= 1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // Stops sending and waits until every expected response has come back.
   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Sends one request, with the sender idling between bursts.
   task automatic send_request(logic [3:0] cmd, int v, int v2);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1;
      req_command <= cmd;
      req_value <= 17'(v);
      req_second_value <= 16'(v2);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic int rand_index();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(65500, 65535);
         2: return -1;
         default: return $urandom_range(0, 120);
      endcase
   endfunction

   task automatic random_phase(int n);
      int c;
      for (int k = 0; k < n; k++) begin
         c = $urandom_range(0, 19);
         if (c < 11) send_request(4'(c), rand_index(), rand_index());
         else if (c < 14) send_request(CMD_ADD, $urandom_range(0, 80), 0);
         else if (c < 15) send_request(CMD_GET, $urandom_range(0, 70) - 1, 0);
         else if (c < 16)
            send_request(CMD_FILL, $urandom_range(0, 40) - 1, $urandom_range(0, 110));
         else if (c < 17) send_request(4'($urandom_range(11, 15)), rand_index(), 0);
         else send_request(CMD_CONTAINS, $urandom_range(0, 80), 0);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_command = 0;
      req_value = 0;
      req_second_value = 0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Single mode: negative clears, toggle of first entry clears.
      send_request(CMD_ADD, 5, 0);
      send_request(CMD_TOGGLE, 5, 0);
      send_request(CMD_TOGGLE, 65535, 0);
      send_request(CMD_SELECT_ONLY, -1, 0);
      send_request(CMD_ADD, 0, 0);
      send_request(CMD_ADD, -65536, 0);
      send_request(CMD_FILL, -3, 9);
      send_request(CMD_FILL, 9, 3);
      wait_drained();
      write_mode(1);

      // Multiple mode: overflowing fill, full add, shifts at the top, swaps, gets.
      send_request(CMD_FILL, 65500, 65535);
      send_request(CMD_ADD, 100, 0);
      send_request(CMD_TOGGLE, 7, 0);
      send_request(CMD_SHIFT_UP, -1, 0);
      send_request(CMD_SHIFT_UP, 65535, 0);
      send_request(CMD_GET, 35, 0);
      send_request(CMD_GET, -65536, 0);
      send_request(CMD_GET, 64, 0);
      send_request(CMD_CLEAR, 0, 0);
      send_request(CMD_FILL, 0, 65535);
      send_request(CMD_ADD, 65535, 0);
      send_request(CMD_SWAP, 3, 65535);
      send_request(CMD_SHIFT_DOWN, 3, 0);
      send_request(CMD_CONTAINS, 65535, 0);
      send_request(CMD_REMOVE, 0, 0);
      send_request(CMD_SWAP, 1, 2);
      send_request(CMD_SHIFT_DOWN, 65535, 0);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         write_mode(ph % 3 != 2);
         random_phase(190);
         wait_drained();
      end

      $display("Covered directed corner cases and %0d responses over single and multiple mode.",
         response_total);
      if (error_count == 0) $display("tb_sorted_index_set_core: PASS");
      else $display("tb_sorted_index_set_core: FAIL");
      $finish;
   end

   initial begin
      #30000000;
      $display("tb_sorted_index_set_core: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
src/sis_pkg.sv
src/sis_ram.sv
src/sorted_index_set_core.sv
verif/sis_checker.sv
verif/tb_sorted_index_set_core.sv
